@@ rtl/ppa_pkg.sv @@
package ppa_pkg;

	// fixed field widths and polygon limits
	localparam int CW         = 16;
	localparam int FRAC       = 8;
	localparam int MAX_POINTS = 8;
	localparam int MIN_POINTS = 3;
	localparam int PERIM_W    = 28;
	localparam int CNT_W      = 4;
	localparam int TALLY_SAT  = MAX_POINTS + 1;

	// square root sizing: radicand is (dx^2 + dy^2) << 2*FRAC, padded to even width
	localparam int SQ_W   = 2 * CW + 1;
	localparam int RAD_W  = ((SQ_W + 2 * FRAC + 1) / 2) * 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int ITER_W = $clog2(ROOT_W);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2
	} status_t;

	// job per vertex bar a non-last first: edge from prev if any, closing on last
	typedef struct packed {
		logic             has_edge;
		logic             last;
		logic [CW-1:0]    dx1;
		logic [CW-1:0]    dy1;
		logic [CW-1:0]    dx2;
		logic [CW-1:0]    dy2;
		logic [CNT_W-1:0] count;
		status_t          status;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQX,
		BK_SQY,
		BK_SUM,
		BK_ROOT,
		BK_ACC,
		BK_EMIT
	} bk_state_t;

endpackage

@@ rtl/ppa_ifs.sv @@
// vertex channel
interface ppa_vtx_if import ppa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] x_coord;
	logic signed [CW-1:0] y_coord;
	logic                 last_vertex;

	modport source (output valid, x_coord, y_coord, last_vertex, input ready);
	modport sink (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

// result channel
interface ppa_res_if import ppa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   vertex_count;
	logic [PERIM_W-1:0] perimeter_q8;
	status_t            status;

	modport source (output valid, vertex_count, perimeter_q8, status, input ready);
	modport sink (input valid, vertex_count, perimeter_q8, status, output ready);
endinterface

@@ rtl/ppa_front.sv @@
module ppa_front import ppa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	ppa_vtx_if.sink  vtx,
	input  logic     q_full,
	output logic     q_push,
	output job_t     q_job
);

	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]     tally_q;
	logic                 accept;
	logic                 is_first;
	logic signed [CW-1:0] fx, fy;
	logic [CNT_W-1:0]     tally_nxt;

	function automatic logic [CW-1:0] abs_diff(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = (CW+1)'(a) - (CW+1)'(b);
		return d[CW] ? CW'(-d) : CW'(d);
	endfunction

	assign vtx.ready = !q_full;
	assign accept    = vtx.valid && vtx.ready;
	assign is_first  = (tally_q == '0);

	// classify the word: first vertex, edge vertex, final vertex
	always_comb begin
		fx = is_first ? vtx.x_coord : first_x_q;
		fy = is_first ? vtx.y_coord : first_y_q;
		if (is_first) begin
			tally_nxt = CNT_W'(1);
		end else if (tally_q < CNT_W'(TALLY_SAT)) begin
			tally_nxt = tally_q + CNT_W'(1);
		end else begin
			tally_nxt = tally_q;
		end

		q_job.has_edge = !is_first;
		q_job.last     = vtx.last_vertex;
		q_job.dx1      = abs_diff(vtx.x_coord, prev_x_q);
		q_job.dy1      = abs_diff(vtx.y_coord, prev_y_q);
		q_job.dx2      = abs_diff(fx, vtx.x_coord);
		q_job.dy2      = abs_diff(fy, vtx.y_coord);
		q_job.count    = tally_nxt;
		priority if (tally_nxt < CNT_W'(MIN_POINTS)) begin
			q_job.status = ST_FEW;
		end else if (tally_nxt > CNT_W'(MAX_POINTS)) begin
			q_job.status = ST_MANY;
		end else begin
			q_job.status = ST_OK;
		end
	end

	// a first vertex that is not also the last carries no work
	assign q_push = accept && (!is_first || vtx.last_vertex);

	// polygon state, cleared after the final vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			tally_q   <= '0;
		end else if (accept) begin
			if (vtx.last_vertex) begin
				first_x_q <= '0;
				first_y_q <= '0;
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				tally_q   <= '0;
			end else begin
				first_x_q <= fx;
				first_y_q <= fy;
				prev_x_q  <= vtx.x_coord;
				prev_y_q  <= vtx.y_coord;
				tally_q   <= tally_nxt;
			end
		end
	end

endmodule

@@ rtl/ppa_queue.sv @@
module ppa_queue import ppa_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	job_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] fill_q;

	assign full     = (fill_q == CNTW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign head_job = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNTW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNTW'(1);
			end
		end
	end

endmodule

@@ rtl/ppa_back.sv @@
module ppa_back import ppa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  job_t      q_job,
	output logic      q_pop,
	ppa_res_if.source res
);

	bk_state_t           state_q, state_nxt;
	job_t                job_q;
	logic                close_q;
	logic [2*CW-1:0]     sqx_q, sqy_q;
	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W-1:0]   root_q;
	logic [REM_W-1:0]    rem_q;
	logic [ITER_W-1:0]   iter_q;
	logic [PERIM_W-1:0]  sum_q;
	logic                res_valid_q;
	logic [CNT_W-1:0]    res_count_q;
	logic [PERIM_W-1:0]  res_perim_q;
	status_t             res_status_q;

	logic [CW-1:0]       mul_op;
	logic [2*CW-1:0]     mul;
	logic [REM_W-1:0]    rem_sh, trial;
	logic                take;
	logic [PERIM_W:0]    sum_add;
	logic                out_free;

	// shared squarer
	always_comb begin
		unique case ({state_q == BK_SQY, close_q})
			2'b00:   mul_op = job_q.dx1;
			2'b01:   mul_op = job_q.dx2;
			2'b10:   mul_op = job_q.dy1;
			default: mul_op = job_q.dy2;
		endcase
		mul = mul_op * mul_op;
	end

	// one root digit per cycle
	assign rem_sh  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign take    = (rem_sh >= trial);
	assign sum_add = {1'b0, sum_q} + (PERIM_W+1)'(root_q);

	assign out_free = !res_valid_q || res.ready;

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					state_nxt = BK_SQX;
				end
			end
			BK_SQX:  state_nxt = BK_SQY;
			BK_SQY:  state_nxt = BK_SUM;
			BK_SUM:  state_nxt = BK_ROOT;
			BK_ROOT: begin
				if (iter_q == ITER_W'(ROOT_W - 1)) begin
					state_nxt = BK_ACC;
				end
			end
			BK_ACC: begin
				if (!job_q.last) begin
					state_nxt = BK_IDLE;
				end else if (!close_q) begin
					state_nxt = BK_SQX;
				end else begin
					state_nxt = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// edge datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				job_q   <= q_job;
				close_q <= !q_job.has_edge;
			end
			BK_SQX: sqx_q <= mul;
			BK_SQY: sqy_q <= mul;
			BK_SUM: begin
				rad_q  <= RAD_W'({1'b0, sqx_q} + {1'b0, sqy_q}) << (2 * FRAC);
				root_q <= '0;
				rem_q  <= '0;
				iter_q <= '0;
			end
			BK_ROOT: begin
				rad_q  <= rad_q << 2;
				iter_q <= iter_q + ITER_W'(1);
				if (take) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			BK_ACC: close_q <= 1'b1;
			default: ;
		endcase
	end

	// running perimeter, saturating, cleared once the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (state_q == BK_ACC) begin
			sum_q <= sum_add[PERIM_W] ? '1 : sum_add[PERIM_W-1:0];
		end else if (state_q == BK_EMIT && out_free) begin
			sum_q <= '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == BK_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_EMIT && out_free) begin
			res_count_q  <= job_q.count;
			res_status_q <= job_q.status;
			res_perim_q  <= (job_q.status == ST_OK) ? sum_q : '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.vertex_count = res_count_q;
	assign res.perimeter_q8 = res_perim_q;
	assign res.status       = res_status_q;

endmodule

@@ rtl/polygon_perimeter_accumulator_unit.sv @@
// in the back end an edge is two squares, a sum, ROOT_W root digits and an add
// a queued vertex is accepted from the channel and its edge is then worked in the back end;
// the final vertex runs its edge from the previous vertex, if any, and the closing edge
// the single square root unit sets the throughput; the job queue lets vertices in meanwhile
// arst_n clears polygon state, queue pointers, perimeter sum and the result valid

module polygon_perimeter_accumulator_unit import ppa_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	ppa_vtx_if.sink   vtx,
	ppa_res_if.source res
);

	logic q_push, q_full, q_pop, q_empty;
	job_t push_job, head_job;

	// accept and classify
	ppa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	// job queue between front and back
	ppa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	// edge lengths, perimeter and result
	ppa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (head_job),
		.q_pop   (q_pop),
		.res     (res)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("job queue underflow");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |-> (res.perimeter_q8 == '0))
		else $error("nonzero perimeter on error status");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_OK) |->
		(res.vertex_count >= CNT_W'(MIN_POINTS) && res.vertex_count <= CNT_W'(MAX_POINTS)))
		else $error("ok status with out-of-range vertex count");

endmodule

@@ sim/polygon_perimeter_accumulator_unit_tb.sv @@
`timescale 1ns / 100ps

module polygon_perimeter_accumulator_unit_tb import ppa_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;

	// expected polygon results, worked out vertex by vertex
	class perimeter_scoreboard;
		typedef struct {
			logic [CNT_W-1:0]   count;
			logic [PERIM_W-1:0] perim;
			status_t            status;
		} poly_result_t;

		poly_result_t          pending_q[$];
		logic signed [CW-1:0]  first_x, first_y, prev_x, prev_y;
		logic [CNT_W-1:0]      tally;
		logic [PERIM_W-1:0]    perim_sum;
		int                    errors;
		int                    polygons_checked;
		int                    ok_seen, few_seen, many_seen;

		function new();
			errors = 0;
			polygons_checked = 0;
			ok_seen = 0;
			few_seen = 0;
			many_seen = 0;
			clear_polygon();
		endfunction

		function void clear_polygon();
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			tally = '0;
			perim_sum = '0;
		endfunction

		// floor square root, one root bit at a time from the top
		function longint unsigned floor_sqrt(input longint unsigned rad);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int i = 27; i >= 0; i--) begin
				trial = root | (64'd1 << i);
				if (trial * trial <= rad)
					root = trial;
			end
			return root;
		endfunction

		// edge length with FRAC fraction bits, truncated
		function longint unsigned edge_q8(input logic signed [CW-1:0] ax, ay, bx, by);
			longint          dx, dy;
			longint unsigned sq;
			dx = longint'(bx) - longint'(ax);
			dy = longint'(by) - longint'(ay);
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			sq = longint'(dx * dx + dy * dy);
			return floor_sqrt(sq << (2 * FRAC));
		endfunction

		// running sum clamps at the top of its range
		function void add_edge(input longint unsigned len);
			longint unsigned total;
			total = longint'(perim_sum) + len;
			if (total > ((64'd1 << PERIM_W) - 1))
				total = (64'd1 << PERIM_W) - 1;
			perim_sum = total[PERIM_W-1:0];
		endfunction

		function void note_vertex(input logic signed [CW-1:0] x, y, input logic last);
			poly_result_t r;
			if (tally == 0) begin
				first_x = x;
				first_y = y;
				tally = 1;
			end else begin
				add_edge(edge_q8(prev_x, prev_y, x, y));
				if (tally < TALLY_SAT)
					tally++;
			end
			prev_x = x;
			prev_y = y;
			if (last) begin
				add_edge(edge_q8(x, y, first_x, first_y));
				r.count = tally;
				if (tally < MIN_POINTS)
					r.status = ST_FEW;
				else if (tally > MAX_POINTS)
					r.status = ST_MANY;
				else
					r.status = ST_OK;
				r.perim = (r.status == ST_OK) ? perim_sum : '0;
				pending_q.push_back(r);
				clear_polygon();
			end
		endfunction

		function void check_result(input logic [CNT_W-1:0] count,
				input logic [PERIM_W-1:0] perim, input status_t status);
			poly_result_t e;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result: count %0d perimeter %0d status %0d",
					$time, count, perim, status);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			polygons_checked++;
			case (e.status)
				ST_OK:   ok_seen++;
				ST_FEW:  few_seen++;
				default: many_seen++;
			endcase
			if (count !== e.count) begin
				$display("%0t mismatch vertex_count: expected %0d, got %0d",
					$time, e.count, count);
				errors++;
			end
			if (perim !== e.perim) begin
				$display("%0t mismatch perimeter_q8: expected %0d, got %0d",
					$time, e.perim, perim);
				errors++;
			end
			if (status !== e.status) begin
				$display("%0t mismatch status: expected %0d, got %0d",
					$time, e.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   rx_hold_req;
	int   rx_hold_left = 0;
	bit   rx_hold_taken = 1'b0;
	int   vertices_sent;
	int   cycle_count = 0;

	perimeter_scoreboard sb;

	ppa_vtx_if vtx_ch ();
	ppa_res_if res_ch ();

	polygon_perimeter_accumulator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx_ch),
		.res    (res_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// accepted vertex words feed the predictor
	always @(posedge clk)
		if (arst_n && vtx_ch.valid && vtx_ch.ready)
			sb.note_vertex(vtx_ch.x_coord, vtx_ch.y_coord, vtx_ch.last_vertex);

	// accepted result words are checked in order
	always @(posedge clk)
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.vertex_count, res_ch.perimeter_q8, res_ch.status);

	// result side back-pressure, with a one-time long hold-off
	always @(posedge clk) begin
		if (rx_hold_req > 0 && !rx_hold_taken) begin
			rx_hold_left = rx_hold_req;
			rx_hold_taken = 1'b1;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(3))
			0: return CW'($urandom);
			1: return CW'(int'($urandom_range(200)) - 100);
			2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			default: return CW'(int'($urandom_range(4000)) - 2000);
		endcase
	endfunction

	task automatic send_vertex(input logic signed [CW-1:0] x, y, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			vtx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_ch.valid       <= 1'b1;
		vtx_ch.x_coord     <= x;
		vtx_ch.y_coord     <= y;
		vtx_ch.last_vertex <= last;
		@(posedge clk);
		while (!vtx_ch.ready)
			@(posedge clk);
		vertices_sent++;
	endtask

	task automatic send_polygon(input int n);
		for (int i = 0; i < n; i++)
			send_vertex(pick_coord(), pick_coord(), i == n - 1);
	endtask

	// mostly legal polygons, with short and over-long ones mixed in
	task automatic send_random_until(input int target);
		int r;
		while (vertices_sent < target) begin
			r = $urandom_range(99);
			if (r < 8)
				send_polygon($urandom_range(2, 1));
			else if (r < 16)
				send_polygon($urandom_range(14, MAX_POINTS + 1));
			else
				send_polygon($urandom_range(MAX_POINTS, MIN_POINTS));
		end
	endtask

	task automatic drain_results();
		vtx_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		tx_idle_pct = 34;
		rx_idle_pct = 52;
		rx_hold_req = 0;
		vertices_sent = 0;
		arst_n = 1'b0;
		vtx_ch.valid       <= 1'b0;
		vtx_ch.x_coord     <= '0;
		vtx_ch.y_coord     <= '0;
		vtx_ch.last_vertex <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertex, then a bare pair: both too short
		send_vertex(16'sh7fff, 16'sh8000, 1'b1);
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b1);
		// triangle spanning the full coordinate range
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh8000, 16'sh7fff, 1'b1);
		// largest legal polygon, corners and axis crossings
		send_vertex(16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh8000, 1'b0);
		send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
		send_vertex(16'sh8000, 16'sh7fff, 1'b0);
		send_vertex(16'sh0000, 16'sh7fff, 1'b0);
		send_vertex(-16'sd1, 16'sh0000, 1'b0);
		send_vertex(16'sh7fff, 16'sh0000, 1'b0);
		send_vertex(16'sh0000, -16'sd1, 1'b1);
		// too many vertices, count saturates
		for (int i = 0; i < 10; i++)
			send_vertex(i[0] ? 16'sh7fff : 16'sh8000, i[1] ? 16'sh7fff : 16'sh8000,
				i == 9);

		// receiver stalls for a long stretch while vertices keep coming
		rx_hold_req = 400;
		send_random_until(470);
		drain_results();

		tx_idle_pct = 52;
		rx_idle_pct = 34;
		send_random_until(940);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random_until(1400);
		drain_results();
		repeat (100) @(posedge clk);

		$display("run covered %0d vertices in %0d polygons: %0d ok, %0d too short, %0d too long",
			vertices_sent, sb.polygons_checked, sb.ok_seen, sb.few_seen, sb.many_seen);
		$display("idle mixes 34/52, 52/34 and none, with one 400-cycle receiver stall");
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ppa_pkg.sv
rtl/ppa_ifs.sv
rtl/ppa_front.sv
rtl/ppa_queue.sv
rtl/ppa_back.sv
rtl/polygon_perimeter_accumulator_unit.sv
sim/polygon_perimeter_accumulator_unit_tb.sv
